// File: hw/rtl/price_level_book_insert_assert.svh
// assertion macros for the price level book checker
// no dependencies; included by the checker module only
`ifndef PRICE_LEVEL_BOOK_INSERT_ASSERT_SVH
`define PRICE_LEVEL_BOOK_INSERT_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define PLBI_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("plbi assertion failed");

// consequent must hold in the cycle after the antecedent
`define PLBI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("plbi assertion failed");

`endif

// File: hw/rtl/plbi_pkg.sv
// shared types and constants for the price level book insert block
// no dependencies; imported by every rtl module of the block
package plbi_pkg;

    localparam int PRICE_W    = 32;
    localparam int VOLUME_W   = 32;
    localparam int COUNT_W    = 4;
    localparam int LEVELS_DEF = 10;

    localparam int IN_TDATA_W = PRICE_W + VOLUME_W;

    // packed from lsb: best_price, best_volume, best_valid, level_count,
    // purged_levels, evicted, merged
    typedef struct packed {
        logic                merged;
        logic                evicted;
        logic [COUNT_W-1:0]  purged_levels;
        logic [COUNT_W-1:0]  level_count;
        logic                best_valid;
        logic [VOLUME_W-1:0] best_volume;
        logic [PRICE_W-1:0]  best_price;
    } plbi_result_t;

    localparam int OUT_FIELDS_W = $bits(plbi_result_t);
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

endpackage

// File: hw/rtl/plbi_update.sv
// combinational book update for one tick: purge, merge or insert, evict
// depends on plbi_pkg
module plbi_update
    import plbi_pkg::*;
#(
    parameter int LEVELS = LEVELS_DEF,
    localparam int CNT_W = $clog2(LEVELS + 1)
)
(
    input  logic                              side,
    input  logic [PRICE_W-1:0]                tick_price,
    input  logic [VOLUME_W-1:0]               tick_volume,
    input  logic [CNT_W-1:0]                  held,
    input  logic [LEVELS-1:0][PRICE_W-1:0]    price_in,
    input  logic [LEVELS-1:0][VOLUME_W-1:0]   volume_in,
    output logic [LEVELS-1:0][PRICE_W-1:0]    price_out,
    output logic [LEVELS-1:0][VOLUME_W-1:0]   volume_out,
    output logic [CNT_W-1:0]                  held_out,
    output plbi_result_t                      result
);

    logic [LEVELS-1:0]                 valid;
    logic [LEVELS-1:0]                 gt;
    logic [LEVELS-1:0]                 eq;
    logic [LEVELS-1:0]                 tick_beats;
    logic [LEVELS-1:0]                 keep;
    logic [LEVELS-1:0]                 first_eq;
    logic                              purge;
    logic                              found;
    logic [LEVELS-1:0][CNT_W-1:0]      dest;
    logic [CNT_W-1:0]                  kept_cnt;
    logic [CNT_W-1:0]                  purged_cnt;

    logic [LEVELS-1:0][PRICE_W-1:0]    c_price;
    logic [LEVELS-1:0][VOLUME_W-1:0]   c_volume;
    logic [LEVELS-1:0]                 c_valid;
    logic [LEVELS-1:0]                 c_tick_beats;
    logic [LEVELS-1:0]                 c_merge;
    logic [LEVELS-1:0][PRICE_W-1:0]    sh_price;
    logic [LEVELS-1:0][VOLUME_W-1:0]   sh_volume;

    logic [VOLUME_W-1:0]               merge_volume;
    logic [VOLUME_W:0]                 merge_sum;
    logic [VOLUME_W-1:0]               merge_sat;
    logic [LEVELS-1:0]                 stop;
    logic [LEVELS-1:0]                 at_pos;
    logic [LEVELS-1:0]                 before_pos;
    logic                              evict;

    // per-slot compares against the tick
    always_comb
    begin
        for (int i = 0; i < LEVELS; i++)
        begin
            valid[i]      = CNT_W'(i) < held;
            gt[i]         = valid[i] && (side ? (price_in[i] < tick_price)
                                              : (price_in[i] > tick_price));
            eq[i]         = valid[i] && (price_in[i] == tick_price);
            tick_beats[i] = valid[i] && !gt[i] && !eq[i];
        end
        purge    = gt[0];
        keep     = purge ? (valid & ~gt) : valid;
        first_eq = eq & (~eq + LEVELS'(1));
        found    = |eq;
        for (int i = 0; i < LEVELS; i++)
        begin
            dest[i] = CNT_W'($countones(keep & ((LEVELS'(1) << i) - LEVELS'(1))));
        end
        kept_cnt   = CNT_W'($countones(keep));
        purged_cnt = purge ? CNT_W'($countones(gt)) : '0;
    end

    // squeeze out purged slots, carrying the flags along
    always_comb
    begin
        for (int k = 0; k < LEVELS; k++)
        begin
            c_price[k]      = '0;
            c_volume[k]     = '0;
            c_tick_beats[k] = 1'b0;
            c_merge[k]      = 1'b0;
            for (int i = 0; i < LEVELS; i++)
            begin
                if (keep[i] && (dest[i] == CNT_W'(k)))
                begin
                    c_price[k]      = c_price[k] | price_in[i];
                    c_volume[k]     = c_volume[k] | volume_in[i];
                    c_tick_beats[k] = c_tick_beats[k] | tick_beats[i];
                    c_merge[k]      = c_merge[k] | first_eq[i];
                end
            end
            c_valid[k] = CNT_W'(k) < kept_cnt;
        end
    end

    // saturating add for the matched level
    always_comb
    begin
        merge_volume = '0;
        for (int i = 0; i < LEVELS; i++)
        begin
            if (first_eq[i])
            begin
                merge_volume = merge_volume | volume_in[i];
            end
        end
        merge_sum = {1'b0, merge_volume} + {1'b0, tick_volume};
        merge_sat = merge_sum[VOLUME_W] ? '1 : merge_sum[VOLUME_W-1:0];
    end

    // insert position is the first slot the tick beats or the first empty one
    always_comb
    begin
        stop       = c_tick_beats | ~c_valid;
        at_pos     = stop & (~stop + LEVELS'(1));
        before_pos = at_pos - LEVELS'(1);
        sh_price[0]  = '0;
        sh_volume[0] = '0;
        for (int k = 1; k < LEVELS; k++)
        begin
            sh_price[k]  = c_price[k-1];
            sh_volume[k] = c_volume[k-1];
        end
        for (int k = 0; k < LEVELS; k++)
        begin
            if (found)
            begin
                price_out[k]  = c_price[k];
                volume_out[k] = c_merge[k] ? merge_sat : c_volume[k];
            end
            else if (before_pos[k])
            begin
                price_out[k]  = c_price[k];
                volume_out[k] = c_volume[k];
            end
            else if (at_pos[k])
            begin
                price_out[k]  = tick_price;
                volume_out[k] = tick_volume;
            end
            else
            begin
                price_out[k]  = sh_price[k];
                volume_out[k] = sh_volume[k];
            end
        end
    end

    always_comb
    begin
        evict = !found && (kept_cnt == CNT_W'(LEVELS));
        if (found || evict)
        begin
            held_out = kept_cnt;
        end
        else
        begin
            held_out = kept_cnt + CNT_W'(1);
        end
        result.best_valid    = held_out != '0;
        result.best_price    = result.best_valid ? price_out[0] : '0;
        result.best_volume   = result.best_valid ? volume_out[0] : '0;
        result.level_count   = COUNT_W'(held_out);
        result.purged_levels = COUNT_W'(purged_cnt);
        result.evicted       = evict;
        result.merged        = found;
    end

endmodule

// File: hw/rtl/plbi_out_reg.sv
// result register with stream handshake on the master side
// depends on plbi_pkg
module plbi_out_reg
    import plbi_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   load,
    input  plbi_result_t           result,
    output logic                   ready,
    output logic                   tvalid,
    input  logic                   tready,
    output logic [OUT_TDATA_W-1:0] tdata
);

    logic                   tvalid_reg;
    logic                   tvalid_next;
    logic [OUT_TDATA_W-1:0] tdata_reg;

    assign ready  = !tvalid_reg || tready;
    assign tvalid = tvalid_reg;
    assign tdata  = tdata_reg;

    always_comb
    begin
        if (load)
        begin
            tvalid_next = 1'b1;
        end
        else if (tready)
        begin
            tvalid_next = 1'b0;
        end
        else
        begin
            tvalid_next = tvalid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tvalid_reg <= 1'b0;
        end
        else
        begin
            tvalid_reg <= tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            tdata_reg <= OUT_TDATA_W'(result);
        end
    end

endmodule

// File: hw/rtl/price_level_book_insert.sv
// path: a tick passes through the input register, then the result register, before its
//   result transaction
// throughput: one tick per cycle while the result side accepts; the book registers
//   close a loop through the compare, compaction and shift-insert logic of plbi_update
// reset: clears the level count, side select and both valid flags; stored levels are
//   not cleared and are never read past the level count
module price_level_book_insert
    import plbi_pkg::*;
#(
    parameter int LEVELS = LEVELS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // configuration: book_side (0 bid, 1 ask)
    input  logic                   cfg_we,
    input  logic                   cfg_wdata,
    // ticks in
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // tick_price, tick_volume
    // results out
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata    // best_price, best_volume, best_valid,
                                                   // level_count, purged_levels, evicted,
                                                   // merged, zero pad
);

    localparam int CNT_W = $clog2(LEVELS + 1);

    // side select
    logic                             book_side_reg;

    // input register
    logic                             in_valid_reg;
    logic                             in_valid_next;
    logic [PRICE_W-1:0]               in_price_reg;
    logic [VOLUME_W-1:0]              in_volume_reg;

    // book state, slot 0 is best
    logic [LEVELS-1:0][PRICE_W-1:0]   book_price_reg;
    logic [LEVELS-1:0][VOLUME_W-1:0]  book_volume_reg;
    logic [CNT_W-1:0]                 held_reg;
    logic [LEVELS-1:0][PRICE_W-1:0]   book_price_next;
    logic [LEVELS-1:0][VOLUME_W-1:0]  book_volume_next;
    logic [CNT_W-1:0]                 held_next;

    plbi_result_t                     result;
    logic                             out_ready;
    logic                             fire;

    // a tick is processed when the result register can take it
    assign fire          = in_valid_reg && out_ready;
    assign s_axis_tready = !in_valid_reg || fire;

    always_comb
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_valid_next = 1'b1;
        end
        else if (fire)
        begin
            in_valid_next = 1'b0;
        end
        else
        begin
            in_valid_next = in_valid_reg;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            book_side_reg <= 1'b0;
            in_valid_reg  <= 1'b0;
            held_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                book_side_reg <= cfg_wdata;
            end
            in_valid_reg <= in_valid_next;
            if (fire)
            begin
                held_reg <= held_next;
            end
        end
    end

    // input payload capture
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_price_reg  <= s_axis_tdata[PRICE_W-1:0];
            in_volume_reg <= s_axis_tdata[IN_TDATA_W-1:PRICE_W];
        end
    end

    // level storage, written once per processed tick
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            book_price_reg  <= book_price_next;
            book_volume_reg <= book_volume_next;
        end
    end

    // purge, merge, insert and evict in one pass
    plbi_update #(
        .LEVELS (LEVELS)
    ) u_update (
        .side        (book_side_reg),
        .tick_price  (in_price_reg),
        .tick_volume (in_volume_reg),
        .held        (held_reg),
        .price_in    (book_price_reg),
        .volume_in   (book_volume_reg),
        .price_out   (book_price_next),
        .volume_out  (book_volume_next),
        .held_out    (held_next),
        .result      (result)
    );

    // result register decouples a stalled consumer from the book loop
    plbi_out_reg u_out (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (fire),
        .result (result),
        .ready  (out_ready),
        .tvalid (m_axis_tvalid),
        .tready (m_axis_tready),
        .tdata  (m_axis_tdata)
    );

endmodule

// File: hw/rtl/plbi_checker.sv
// port-level checks for price_level_book_insert, bound to the top level
// depends on plbi_pkg and price_level_book_insert_assert.svh
`include "price_level_book_insert_assert.svh"

module plbi_checker
    import plbi_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    plbi_result_t res;

    assign res = m_axis_tdata[OUT_FIELDS_W-1:0];

    // stalled result holds
    `PLBI_ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
    // empty book reports a zero best level
    `PLBI_ASSERT_NOW(a_empty_zero, clk, rst_n, m_axis_tvalid && !res.best_valid, res.best_price == '0 && res.best_volume == '0)
    // a tick either merges or inserts, so it cannot do both
    `PLBI_ASSERT_NOW(a_merge_evict, clk, rst_n, m_axis_tvalid, !(res.merged && res.evicted))
    // a purge frees room, so eviction only follows a tick that purged nothing
    `PLBI_ASSERT_NOW(a_evict_no_purge, clk, rst_n, m_axis_tvalid && res.evicted, res.purged_levels == '0)

endmodule

bind price_level_book_insert plbi_checker u_plbi_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// File: bench/price_level_book_insert_tb.sv
`timescale 1ns / 1ps
// self-checking bench for price_level_book_insert: directed tick table, then random ticks
// in phases with side changes; depends on plbi_pkg and the rtl of the block only

module price_level_book_insert_tb;
    import plbi_pkg::*;

    localparam int BOOK_LEVELS = LEVELS_DEF;
    localparam int RAND_PHASES = 6;
    localparam int PHASE_TICKS = 240;
    localparam int CALM_TICKS  = 150;

    typedef struct {
        bit           side;
        logic [31:0]  price;
        logic [31:0]  volume;
        bit           typed;
        plbi_result_t want;
    } tick_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic                   cfg_wdata;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;   // tick_price, tick_volume
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;   // best_price, best_volume, best_valid,
                                            // level_count, purged_levels, evicted, merged

    // shadow book kept in step with accepted ticks
    logic [31:0]  shadow_price [BOOK_LEVELS];
    logic [31:0]  shadow_volume [BOOK_LEVELS];
    int           shadow_held;
    bit           side_ask;

    plbi_result_t awaited_results [$];
    tick_row_t    tick_table [$];
    plbi_result_t got;
    plbi_result_t want;
    int           mismatches;
    bit           calm;

    price_level_book_insert #(
        .LEVELS (BOOK_LEVELS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // a beats b on the current side
    function automatic bit outranks(logic [31:0] a, logic [31:0] b);
        return side_ask ? (a < b) : (a > b);
    endfunction

    // applies one tick to the shadow book and returns the top-of-book report
    function automatic plbi_result_t book_after_tick(logic [31:0] p, logic [31:0] v);
        int           n;
        int           k;
        int           i;
        int           pos;
        int           purged;
        bit           hit;
        bit           dropped;
        logic [32:0]  sum;
        plbi_result_t r;
        n       = shadow_held;
        purged  = 0;
        hit     = 1'b0;
        dropped = 1'b0;
        // a worse tick means everything better than it traded, wherever it sits
        if (n > 0 && outranks(shadow_price[0], p))
        begin
            k = 0;
            for (i = 0; i < n; i++)
            begin
                if (outranks(shadow_price[i], p))
                    purged++;
                else
                begin
                    shadow_price[k]  = shadow_price[i];
                    shadow_volume[k] = shadow_volume[i];
                    k++;
                end
            end
            n = k;
        end
        for (i = 0; i < n; i++)
        begin
            if (!hit && shadow_price[i] == p)
            begin
                sum              = {1'b0, shadow_volume[i]} + {1'b0, v};
                shadow_volume[i] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                hit              = 1'b1;
            end
        end
        if (!hit)
        begin
            pos = n;
            for (i = 0; i < n; i++)
                if (pos == n && outranks(p, shadow_price[i]))
                    pos = i;
            if (n >= BOOK_LEVELS)
            begin
                dropped = 1'b1;
                n       = BOOK_LEVELS;
                if (pos < BOOK_LEVELS)
                begin
                    for (i = BOOK_LEVELS - 1; i > pos; i--)
                    begin
                        shadow_price[i]  = shadow_price[i-1];
                        shadow_volume[i] = shadow_volume[i-1];
                    end
                    shadow_price[pos]  = p;
                    shadow_volume[pos] = v;
                end
            end
            else
            begin
                for (i = n; i > pos; i--)
                begin
                    shadow_price[i]  = shadow_price[i-1];
                    shadow_volume[i] = shadow_volume[i-1];
                end
                shadow_price[pos]  = p;
                shadow_volume[pos] = v;
                n++;
            end
        end
        shadow_held     = n;
        r.best_price    = (n != 0) ? shadow_price[0] : '0;
        r.best_volume   = (n != 0) ? shadow_volume[0] : '0;
        r.best_valid    = (n != 0);
        r.level_count   = n[COUNT_W-1:0];
        r.purged_levels = purged[COUNT_W-1:0];
        r.evicted       = dropped;
        r.merged        = hit;
        return r;
    endfunction

    // random price steered by the shadow book so merges, purges and evictions all occur
    function automatic logic [31:0] pick_price();
        int          mode;
        logic [31:0] best;
        logic [31:0] d;
        mode = $urandom_range(0, 99);
        if (shadow_held == 0 || mode < 8)
            return $urandom;
        best = shadow_price[0];
        d    = $urandom_range(1, 4);
        if (mode < 13)
            return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
        if (mode < 33)
            return shadow_price[$urandom_range(0, shadow_held - 1)];
        if (mode < 48)
            return side_ask ? best + d : best - d;
        return side_ask ? best - d : best + d;
    endfunction

    function automatic logic [31:0] pick_volume();
        int mode;
        mode = $urandom_range(0, 9);
        if (mode == 0)
            return '0;
        if (mode == 1)
            return 32'hFFFF_FFFF - $urandom_range(0, 255);
        return $urandom;
    endfunction

    function automatic void table_tick(bit side, logic [31:0] p, logic [31:0] v);
        tick_row_t r;
        r.side   = side;
        r.price  = p;
        r.volume = v;
        r.typed  = 1'b0;
        r.want   = '0;
        tick_table.push_back(r);
    endfunction

    function automatic void table_tick_chk(bit side, logic [31:0] p, logic [31:0] v,
                                           logic [31:0] bp, logic [31:0] bv,
                                           logic [3:0] cnt, logic [3:0] purged,
                                           bit ev, bit mg);
        tick_row_t r;
        r.side               = side;
        r.price              = p;
        r.volume             = v;
        r.typed              = 1'b1;
        r.want.best_price    = bp;
        r.want.best_volume   = bv;
        r.want.best_valid    = (cnt != 0);
        r.want.level_count   = cnt;
        r.want.purged_levels = purged;
        r.want.evicted       = ev;
        r.want.merged        = mg;
        tick_table.push_back(r);
    endfunction

    task automatic report_mismatch(string what, logic [31:0] seen, logic [31:0] wanted);
        if (mismatches < 200)
            $display("mismatch %s: got %0h expected %0h at %0t", what, seen, wanted, $realtime);
        mismatches++;
    endtask

    // drives one tick transaction, called at a falling edge and returns at one
    task automatic send_tick(logic [31:0] p, logic [31:0] v, bit typed, plbi_result_t fixed);
        plbi_result_t predicted;
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {v, p};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predicted = book_after_tick(p, v);
        awaited_results.push_back(typed ? fixed : predicted);
        @(negedge clk);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    // side select write, only with the book idle
    task automatic write_side(bit ask);
        cfg_we    <= 1'b1;
        cfg_wdata <= ask;
        @(negedge clk);
        cfg_we    <= 1'b0;
        side_ask   = ask;
    endtask

    // result side back-pressure in random bursts
    initial
    begin
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!calm && $urandom_range(0, 5) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    // every result transaction is checked against the oldest awaited report
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata[OUT_FIELDS_W-1:0];
            if (awaited_results.size() == 0)
                report_mismatch("unexpected result", got.best_price, 32'h0);
            else
            begin
                want = awaited_results.pop_front();
                if (got.best_price !== want.best_price)
                    report_mismatch("best_price", got.best_price, want.best_price);
                if (got.best_volume !== want.best_volume)
                    report_mismatch("best_volume", got.best_volume, want.best_volume);
                if (got.best_valid !== want.best_valid)
                    report_mismatch("best_valid", got.best_valid, want.best_valid);
                if (got.level_count !== want.level_count)
                    report_mismatch("level_count", got.level_count, want.level_count);
                if (got.purged_levels !== want.purged_levels)
                    report_mismatch("purged_levels", got.purged_levels, want.purged_levels);
                if (got.evicted !== want.evicted)
                    report_mismatch("evicted", got.evicted, want.evicted);
                if (got.merged !== want.merged)
                    report_mismatch("merged", got.merged, want.merged);
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        bit side_plan [RAND_PHASES];
        int ph;
        int j;
        int idx;
        side_plan     = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0};
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        shadow_held   = 0;
        side_ask      = 1'b0;
        mismatches    = 0;
        calm          = 1'b0;

        // bid side: empty book, saturating merges, extreme prices, purge of the whole book
        table_tick_chk(0, 100, 5, 100, 5, 1, 0, 0, 0);
        table_tick_chk(0, 100, 32'hFFFF_FFFF, 100, 32'hFFFF_FFFF, 1, 0, 0, 1);
        table_tick_chk(0, 100, 7, 100, 32'hFFFF_FFFF, 1, 0, 0, 1);
        table_tick_chk(0, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, 1, 2, 0, 0, 0);
        table_tick_chk(0, 50, 32'h1234_5678, 50, 32'h1234_5678, 1, 2, 0, 0);
        // fill the book to its limit
        table_tick(0, 60, 0);
        table_tick(0, 70, 32'h8000_0000);
        table_tick(0, 80, 3);
        table_tick(0, 90, 32'h7FFF_FFFF);
        table_tick(0, 100, 11);
        table_tick(0, 110, 32'hDEAD_BEEF);
        table_tick(0, 120, 1);
        table_tick(0, 130, 32'h0001_0000);
        table_tick(0, 140, 32'h0000_00FF);
        // full book, new best pushes out the worst level
        table_tick_chk(0, 200, 32'hA5A5_A5A5, 200, 32'hA5A5_A5A5, 10, 0, 1, 0);
        // side flipped with a full bid-ordered book
        table_tick(1, 105, 0);
        table_tick_chk(1, 300, 1, 300, 1, 1, 10, 0, 0);
        table_tick(1, 32'hFFFF_FFFF, 3);
        table_tick(1, 0, 32'hFFFF_FFFF);
        // back to bid with an ask-ordered book, purge must find levels past slot 0
        table_tick(0, 32'h8000_0000, 9);
        table_tick(0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        table_tick(0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        write_side(1'b0);

        foreach (tick_table[i])
        begin
            if (tick_table[i].side != side_ask)
            begin
                drain_results();
                write_side(tick_table[i].side);
            end
            send_tick(tick_table[i].price, tick_table[i].volume,
                      tick_table[i].typed, tick_table[i].want);
        end

        // random phases, side rewritten between them without clearing the book
        idx = 0;
        for (ph = 0; ph < RAND_PHASES; ph++)
        begin
            drain_results();
            write_side(side_plan[ph]);
            for (j = 0; j < PHASE_TICKS; j++)
            begin
                calm = (idx >= RAND_PHASES * PHASE_TICKS - CALM_TICKS);
                send_tick(pick_price(), pick_volume(), 1'b0, '0);
                idx++;
            end
        end

        drain_results();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/plbi_pkg.sv
hw/rtl/plbi_update.sv
hw/rtl/plbi_out_reg.sv
hw/rtl/price_level_book_insert.sv
hw/rtl/plbi_checker.sv
bench/price_level_book_insert_tb.sv
